// ===== src/cha_pkg.sv =====
// ----------------------------------------------------------------------------
// cha_pkg: shared constants for the compass heading unit
// Widths, the CORDIC angle table and the output scaling constants.
// ----------------------------------------------------------------------------
package cha_pkg;

  localparam int CORDIC_STEPS  = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int N_STEPS       = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN
                                                                : CORDIC_STEPS;
  // Input stage, one stage per micro-rotation, angle fix stage, output stage.
  localparam int NSTG   = N_STEPS + 3;

  localparam int IN_W   = 16;
  localparam int FRAC_W = 16;
  localparam int DW     = 37;
  localparam int AW     = 31;
  localparam int FX_W   = 30;
  localparam int RND_SH = 14;
  localparam int RND_W  = FX_W + 1 - RND_SH;
  localparam int OUT_W  = 15;

  localparam logic signed [AW-1:0] DEG180     = 31'sd188743680;
  localparam logic signed [AW-1:0] DEG360     = 31'sd377487360;
  localparam logic        [FX_W:0] ROUND_HALF = 31'd8192;
  localparam logic       [RND_W-1:0] OUT_FULL = 17'd23040;
  localparam logic       [OUT_W-1:0] OUT_HALF = 15'd11520;

  // atan(2^-i) in degrees, scaled by 2^20 and rounded to nearest.
  function automatic logic signed [AW-1:0] atan_tab(input int unsigned idx);
    logic signed [AW-1:0] v;
    case (idx)
      0:  v = 31'sd47185920;
      1:  v = 31'sd27855475;
      2:  v = 31'sd14718068;
      3:  v = 31'sd7471121;
      4:  v = 31'sd3750058;
      5:  v = 31'sd1876857;
      6:  v = 31'sd938658;
      7:  v = 31'sd469357;
      8:  v = 31'sd234682;
      9:  v = 31'sd117342;
      10: v = 31'sd58671;
      11: v = 31'sd29335;
      12: v = 31'sd14668;
      13: v = 31'sd7334;
      14: v = 31'sd3667;
      15: v = 31'sd1833;
      16: v = 31'sd917;
      17: v = 31'sd458;
      18: v = 31'sd229;
      19: v = 31'sd115;
      20: v = 31'sd57;
      21: v = 31'sd29;
      22: v = 31'sd14;
      23: v = 31'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== src/cha_in_if.sv =====
// ----------------------------------------------------------------------------
// cha_in_if: field vector request channel
// Valid/ready channel carrying one signed x/y magnetometer vector.
// ----------------------------------------------------------------------------
interface cha_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [cha_pkg::IN_W-1:0] vec_x;
  logic signed [cha_pkg::IN_W-1:0] vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

// ===== src/cha_out_if.sv =====
// ----------------------------------------------------------------------------
// cha_out_if: heading result channel
// Valid/ready channel carrying one heading in 1/64 degree units.
// ----------------------------------------------------------------------------
interface cha_out_if;
  logic                      valid;
  logic                      ready;
  logic [cha_pkg::OUT_W-1:0] heading_deg;

  modport source (output valid, output heading_deg, input ready);
  modport sink   (input valid, input heading_deg, output ready);
endinterface

// ===== src/compass_heading_atan2_unit.sv =====
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit: four-quadrant heading by CORDIC vectoring
// Converts a field vector into a heading in [0, 360) degrees, 1/64 degree LSB.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                      Handshake
//  in_ch     sink       vec_x[15:0], vec_y[15:0]     valid/ready
//  out_ch    source     heading_deg[14:0]            valid/ready
//
//  One request is accepted per cycle unless the output stalls. A request
//  passes input, one stage per micro-rotation, angle fix and output stages.
//  Reset clears every stage valid bit; no result is pending after reset.
//  Each stage holds its item while the next one is full and stalled, and an
//  empty stage takes new data, so bubbles collapse under output back-pressure.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit (
  input  logic       clk,
  input  logic       rst_n,
  cha_in_if.sink     in_ch,
  cha_out_if.source  out_ch
);

  localparam int NS   = cha_pkg::N_STEPS;
  localparam int NSTG = cha_pkg::NSTG;
  localparam int DW   = cha_pkg::DW;
  localparam int AW   = cha_pkg::AW;
  localparam int FIX  = NS + 1;
  localparam int LAST = NSTG - 1;

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;
  logic [NSTG-1:0] ld;

  logic signed [DW-1:0] x_r   [NS+1];
  logic signed [DW-1:0] y_r   [NS+1];
  logic signed [AW-1:0] ang_r [NS+1];
  logic signed [DW-1:0] x_nxt [NS+1];
  logic signed [DW-1:0] y_nxt [NS+1];
  logic signed [AW-1:0] ang_nxt [NS+1];
  logic [FIX:0]         spc_r;
  logic [FIX:0]         neg_r;

  logic [cha_pkg::FX_W-1:0]  fx_r;
  logic [cha_pkg::FX_W-1:0]  fx_nxt;
  logic [cha_pkg::OUT_W-1:0] hd_r;
  logic [cha_pkg::OUT_W-1:0] hd_nxt;

  logic signed [DW-1:0]      in_xs;
  logic signed [DW-1:0]      in_ys;
  logic [cha_pkg::FX_W:0]    rsum;
  logic [cha_pkg::RND_W-1:0] rnd;
  logic [cha_pkg::RND_W-1:0] rwrap;

  always_comb begin
    rdy[NSTG] = out_ch.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    ld[0] = rdy[0] && in_ch.valid;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = rdy[k] && vld_r[k-1];
    end
  end

  always_comb begin
    in_xs = {{(DW - cha_pkg::IN_W - cha_pkg::FRAC_W){in_ch.vec_x[cha_pkg::IN_W-1]}},
             in_ch.vec_x, {cha_pkg::FRAC_W{1'b0}}};
    in_ys = {{(DW - cha_pkg::IN_W - cha_pkg::FRAC_W){in_ch.vec_y[cha_pkg::IN_W-1]}},
             in_ch.vec_y, {cha_pkg::FRAC_W{1'b0}}};
    if (in_ch.vec_x[cha_pkg::IN_W-1]) begin
      x_nxt[0]   = -in_xs;
      y_nxt[0]   = -in_ys;
      ang_nxt[0] = cha_pkg::DEG180;
    end else begin
      x_nxt[0]   = in_xs;
      y_nxt[0]   = in_ys;
      ang_nxt[0] = '0;
    end
    for (int k = 1; k <= NS; k++) begin
      if (!y_r[k-1][DW-1]) begin
        x_nxt[k]   = x_r[k-1] + (y_r[k-1] >>> (k - 1));
        y_nxt[k]   = y_r[k-1] - (x_r[k-1] >>> (k - 1));
        ang_nxt[k] = ang_r[k-1] + cha_pkg::atan_tab(k - 1);
      end else begin
        x_nxt[k]   = x_r[k-1] - (y_r[k-1] >>> (k - 1));
        y_nxt[k]   = y_r[k-1] + (x_r[k-1] >>> (k - 1));
        ang_nxt[k] = ang_r[k-1] - cha_pkg::atan_tab(k - 1);
      end
    end
  end

  // A negative angle is brought into the upper half of the circle.
  always_comb begin
    if (ang_r[NS][AW-1]) begin
      fx_nxt = cha_pkg::FX_W'(ang_r[NS] + cha_pkg::DEG360);
    end else begin
      fx_nxt = cha_pkg::FX_W'(ang_r[NS]);
    end
  end

  always_comb begin
    rsum  = {1'b0, fx_r} + cha_pkg::ROUND_HALF;
    rnd   = rsum[cha_pkg::FX_W:cha_pkg::RND_SH];
    rwrap = (rnd >= cha_pkg::OUT_FULL) ? (rnd - cha_pkg::OUT_FULL) : rnd;
    if (spc_r[FIX]) begin
      hd_nxt = neg_r[FIX] ? cha_pkg::OUT_HALF : '0;
    end else begin
      hd_nxt = cha_pkg::OUT_W'(rwrap);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r[0] <= rdy[0] ? in_ch.valid : vld_r[0];
      for (int k = 1; k < NSTG; k++) begin
        vld_r[k] <= rdy[k] ? vld_r[k-1] : vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      x_r[0]   <= x_nxt[0];
      y_r[0]   <= y_nxt[0];
      ang_r[0] <= ang_nxt[0];
      spc_r[0] <= (in_ch.vec_y == '0);
      neg_r[0] <= in_ch.vec_x[cha_pkg::IN_W-1];
    end
    for (int k = 1; k <= NS; k++) begin
      if (ld[k]) begin
        x_r[k]   <= x_nxt[k];
        y_r[k]   <= y_nxt[k];
        ang_r[k] <= ang_nxt[k];
        spc_r[k] <= spc_r[k-1];
        neg_r[k] <= neg_r[k-1];
      end
    end
    if (ld[FIX]) begin
      fx_r       <= fx_nxt;
      spc_r[FIX] <= spc_r[NS];
      neg_r[FIX] <= neg_r[NS];
    end
    if (ld[LAST]) begin
      hd_r <= hd_nxt;
    end
  end

  assign in_ch.ready        = rdy[0];
  assign out_ch.valid       = vld_r[LAST];
  assign out_ch.heading_deg = hd_r;

`ifndef NO_ASSERTIONS
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[LAST] |-> (hd_r < cha_pkg::OUT_W'(cha_pkg::OUT_FULL)))
    else $error("heading out of range");

  a_axis: assert property (@(posedge clk) disable iff (!rst_n)
    (ld[LAST] && spc_r[FIX]) |=>
      (hd_r == '0 || hd_r == cha_pkg::OUT_HALF))
    else $error("x-axis request did not give 0 or 180 degrees");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (&vld_r))
    else $error("input stalled while the pipeline has a bubble");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[FIX] && !rdy[FIX]) |=> (vld_r[FIX] && $stable(fx_r)))
    else $error("stalled stage lost or changed its data");
`endif

endmodule

// ===== sim/compass_heading_atan2_unit_test.sv =====
// ----------------------------------------------------------------------------
// compass_heading_atan2_unit_test: self-checking bench for the heading unit
// Field vectors are driven on the request channel and every heading that comes
// back is checked against a bit-exact CORDIC predictor. The run covers the
// axes, the zero vector, full-scale corners and the 360 degree wrap, and then
// random vectors, with random gaps on requests and back-pressure on results.
// ----------------------------------------------------------------------------
module compass_heading_atan2_unit_test;

  typedef struct packed {
    logic signed [cha_pkg::IN_W-1:0] x;
    logic signed [cha_pkg::IN_W-1:0] y;
  } field_vec_t;

  typedef struct packed {
    field_vec_t                vec;
    logic [cha_pkg::OUT_W-1:0] heading;
  } heading_due_t;

  localparam int     ATAN_ENTRIES   = 24;
  localparam int     ANGLE_FRAC     = 20;
  localparam int     OUT_SHIFT      = 14;
  localparam longint ANGLE_180      = longint'(180) << ANGLE_FRAC;
  localparam longint ANGLE_360      = longint'(360) << ANGLE_FRAC;
  localparam longint ANGLE_ROUND    = longint'(1) << (OUT_SHIFT - 1);
  localparam longint HEADING_FULL   = 23040;
  localparam logic [cha_pkg::OUT_W-1:0] HEADING_SOUTH = 15'd11520;
  localparam int     IN_UNIT        = 65536;
  localparam int     RANDOM_VECTORS = 1230;
  localparam int     IDLE_PCT       = 20;
  localparam int     QUIET_FIRST    = 600;
  localparam int     QUIET_LAST     = 850;
  localparam int     REPORT_LIMIT   = 10;

  localparam longint ATAN_DEG [ATAN_ENTRIES] = '{
    47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
    938658, 469357, 234682, 117342, 58671, 29335,
    14668, 7334, 3667, 1833, 917, 458,
    229, 115, 57, 29, 14, 7
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  cha_in_if  in_ch ();
  cha_out_if out_ch ();

  compass_heading_atan2_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  field_vec_t   vectors_to_send [$];
  heading_due_t headings_due [$];
  int           vectors_sent     = 0;
  int           headings_checked = 0;
  int           directed_count   = 0;
  int           error_count      = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // CORDIC vectoring in 16.16 fixed point with a 2^-20 degree angle sum.
  function automatic logic [cha_pkg::OUT_W-1:0] predict_heading(field_vec_t v);
    longint x;
    longint y;
    longint xs;
    longint ys;
    longint ang;
    int     n_rot;
    x = v.x;
    y = v.y;
    ang = 0;
    n_rot = (cha_pkg::CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : cha_pkg::CORDIC_STEPS;
    if (y == 0) begin
      return (x < 0) ? HEADING_SOUTH : '0;
    end
    x = x * IN_UNIT;
    y = y * IN_UNIT;
    if (x < 0) begin
      x = -x;
      y = -y;
      ang = ANGLE_180;
    end
    for (int i = 0; i < n_rot; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang = ang + ATAN_DEG[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang = ang - ATAN_DEG[i];
      end
    end
    if (ang < 0) begin
      ang = ang + ANGLE_360;
    end
    if (ang < 0) begin
      ang = 0;
    end
    ang = (ang + ANGLE_ROUND) >>> OUT_SHIFT;
    while (ang >= HEADING_FULL) begin
      ang = ang - HEADING_FULL;
    end
    return ang[cha_pkg::OUT_W-1:0];
  endfunction

  function automatic field_vec_t random_vector();
    field_vec_t v;
    logic [cha_pkg::IN_W-1:0] rx;
    logic [cha_pkg::IN_W-1:0] ry;
    int pick;
    rx = cha_pkg::IN_W'($urandom);
    ry = cha_pkg::IN_W'($urandom);
    pick = $urandom_range(9);
    v.x = rx;
    v.y = ry;
    case (pick)
      4, 5: begin
        v.x = cha_pkg::IN_W'($urandom_range(64)) - 16'sd32;
        v.y = cha_pkg::IN_W'($urandom_range(64)) - 16'sd32;
      end
      6: v.y = cha_pkg::IN_W'($urandom_range(6)) - 16'sd3;
      7: v.x = cha_pkg::IN_W'($urandom_range(6)) - 16'sd3;
      8: begin
        v.x = (rx[0]) ? {rx[1], {(cha_pkg::IN_W-1){~rx[1]}}} :
                        {cha_pkg::IN_W{rx[1]}} ^ 16'(rx[2]);
        v.y = (ry[0]) ? {ry[1], {(cha_pkg::IN_W-1){~ry[1]}}} :
                        {cha_pkg::IN_W{ry[1]}} ^ 16'(ry[2]);
      end
      9: v.y = (ry[0]) ? v.x : -v.x;
      default: ;
    endcase
    return v;
  endfunction

  function automatic void note_error(string what, field_vec_t v,
                                     logic [cha_pkg::OUT_W-1:0] want,
                                     logic [cha_pkg::OUT_W-1:0] got);
    error_count++;
    if (error_count <= REPORT_LIMIT) begin
      $display("ERROR %s: x=%0d y=%0d expected=%0d actual=%0d",
               what, v.x, v.y, want, got);
    end
  endfunction

  // Request driver: a new vector goes out only once the previous one is taken.
  always @(posedge clk) begin
    field_vec_t v;
    heading_due_t due;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        due.vec.x   = in_ch.vec_x;
        due.vec.y   = in_ch.vec_y;
        due.heading = predict_heading(due.vec);
        headings_due.push_back(due);
        vectors_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (vectors_to_send.size() != 0 &&
            ((vectors_sent >= QUIET_FIRST && vectors_sent < QUIET_LAST) ||
             $urandom_range(99) >= IDLE_PCT)) begin
          v = vectors_to_send.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.vec_x <= v.x;
          in_ch.vec_y <= v.y;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor with random back-pressure.
  always @(posedge clk) begin
    heading_due_t due;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (headings_due.size() == 0) begin
          note_error("unexpected heading", '0, '0, out_ch.heading_deg);
        end else begin
          due = headings_due.pop_front();
          headings_checked++;
          if (out_ch.heading_deg !== due.heading) begin
            note_error("heading mismatch", due.vec, due.heading, out_ch.heading_deg);
          end
        end
      end
      out_ch.ready <= (headings_checked >= QUIET_FIRST && headings_checked < QUIET_LAST) ||
                      ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin
    field_vec_t directed [$];
    in_ch.valid  = 1'b0;
    in_ch.vec_x  = '0;
    in_ch.vec_y  = '0;
    out_ch.ready = 1'b0;

    // Zero vector, both axes, full-scale corners and the wrap just below 360.
    directed = '{
      '{16'sd0, 16'sd0},          '{16'sd1, 16'sd0},
      '{-16'sd1, 16'sd0},         '{16'sd32767, 16'sd0},
      '{-16'sd32768, 16'sd0},     '{16'sd0, 16'sd32767},
      '{16'sd0, -16'sd32768},     '{16'sd0, 16'sd1},
      '{16'sd0, -16'sd1},         '{16'sd32767, 16'sd32767},
      '{-16'sd32768, -16'sd32768},'{-16'sd32768, 16'sd32767},
      '{16'sd32767, -16'sd32768}, '{-16'sd32768, -16'sd1},
      '{-16'sd32768, 16'sd1},     '{16'sd1, 16'sd1},
      '{-16'sd1, -16'sd1},        '{16'sd1, -16'sd1},
      '{-16'sd1, 16'sd1},         '{16'sd32767, -16'sd1},
      '{16'sd32767, 16'sd1},      '{16'sd20000, -16'sd3},
      '{-16'sd12345, 16'sd23456}
    };
    foreach (directed[i]) begin
      vectors_to_send.push_back(directed[i]);
    end
    directed_count = directed.size();
    for (int i = 0; i < RANDOM_VECTORS; i++) begin
      vectors_to_send.push_back(random_vector());
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (vectors_to_send.size() != 0 || in_ch.valid) begin
      @(posedge clk);
    end
    while (headings_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (cha_pkg::NSTG + 8) @(posedge clk);

    if (headings_due.size() != 0) begin
      error_count += headings_due.size();
      $display("ERROR %0d headings never arrived", headings_due.size());
    end

    $display("Checked %0d headings for %0d vectors (%0d directed, %0d random).",
             headings_checked, vectors_sent, directed_count, RANDOM_VECTORS);
    $display("Directed set covered the zero vector, both axes, corners and 360 wrap; "
             , "%0d errors.", error_count);
    if (error_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
